// ===== hw/rtl/bfp_pkg.sv =====
// Shared types, constants and helpers for the fern point plotter.
// Holds the map coefficients, image geometry, scale factors and sequencer states.
// No dependencies; compile first.
package bfp_pkg;

    localparam int IMG_WIDTH  = 256;
    localparam int IMG_HEIGHT = 256;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    localparam int BM_BYTES = (IMG_WIDTH * IMG_HEIGHT + 7) / 8;
    localparam int BM_AW    = $clog2(BM_BYTES);

    localparam int MUL_A_W = 22;
    localparam int MUL_B_W = 34;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic signed [MUL_P_W-1:0] ROUND_BIAS = MUL_P_W'(32768);

    localparam longint DEN_X   = 11 * 65536;
    localparam longint DEN_Y   = 21 * 65536;
    localparam int     SHX     = 40;
    localparam int     SHY     = 41;
    localparam int     Q_W     = 15;
    localparam longint MUL_X   = (2 * longint'(IMG_WIDTH) * (longint'(1) << SHX) + DEN_X - 1)
                                 / DEN_X;
    localparam longint MUL_Y   = (2 * longint'(IMG_HEIGHT) * (longint'(1) << SHY) + DEN_Y - 1)
                                 / DEN_Y;
    localparam logic signed [MUL_B_W-1:0] SCALE_X_MUL = MUL_B_W'(MUL_X);
    localparam logic signed [MUL_B_W-1:0] SCALE_Y_MUL = MUL_B_W'(MUL_Y);

    localparam logic signed [15:0] HALF_W = 16'(IMG_WIDTH / 2);
    localparam logic signed [15:0] W_S    = 16'(IMG_WIDTH);
    localparam logic signed [15:0] H_S    = 16'(IMG_HEIGHT);

    localparam logic [2:0] CF_A = 3'd0;
    localparam logic [2:0] CF_B = 3'd1;
    localparam logic [2:0] CF_E = 3'd2;
    localparam logic [2:0] CF_C = 3'd3;
    localparam logic [2:0] CF_D = 3'd4;
    localparam logic [2:0] CF_F = 3'd5;

    localparam logic [1:0] MAP_STEM  = 2'd0;
    localparam logic [1:0] MAP_MAIN  = 2'd1;
    localparam logic [1:0] MAP_LEFT  = 2'd2;
    localparam logic [1:0] MAP_RIGHT = 2'd3;

    localparam logic [6:0] SEL_LEFT  = 7'd86;
    localparam logic [6:0] SEL_RIGHT = 7'd93;

    localparam logic OP_STEP = 1'b0;
    localparam logic OP_READ = 1'b1;

    // a, b, e, c, d, f in Q16
    localparam logic signed [17:0] MAP_COEF [4][6] = '{
        '{18'sd0,      18'sd0,      18'sd0, 18'sd0,     18'sd10486, 18'sd0},
        '{18'sd55706,  18'sd2621,   18'sd0, -18'sd2621, 18'sd55706, 18'sd104858},
        '{18'sd13107,  -18'sd17039, 18'sd0, 18'sd15073, 18'sd14418, 18'sd104858},
        '{-18'sd9830,  18'sd18350,  18'sd0, 18'sd17039, 18'sd15729, 18'sd28836}
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AX,
        ST_BY,
        ST_CX,
        ST_DY,
        ST_SX,
        ST_SY,
        ST_PIX,
        ST_WR,
        ST_RADDR,
        ST_DONE
    } bfp_state_t;

    typedef struct packed {
        logic             rd_en;
        logic             wr_en;
        logic [BM_AW-1:0] addr;
        logic [7:0]       wr_data;
    } bfp_mem_req_t;

    function automatic logic [1:0] pick_map(input logic [6:0] sel);
        logic [1:0] m;
        if (sel == 7'd0) begin
            m = MAP_STEM;
        end else if (sel < SEL_LEFT) begin
            m = MAP_MAIN;
        end else if (sel < SEL_RIGHT) begin
            m = MAP_LEFT;
        end else begin
            m = MAP_RIGHT;
        end
        return m;
    endfunction

    function automatic logic signed [17:0] map_coef(input logic [1:0] m, input logic [2:0] k);
        return MAP_COEF[m][k];
    endfunction

    function automatic logic signed [20:0] sat_q(input logic signed [40:0] v);
        logic signed [20:0] r;
        if (v > 41'sd1048575) begin
            r = 21'sd1048575;
        end else if (v < -41'sd1048576) begin
            r = -21'sd1048576;
        end else begin
            r = v[20:0];
        end
        return r;
    endfunction

    function automatic logic signed [MUL_A_W-1:0] abs_q(input logic signed [20:0] v);
        logic signed [MUL_A_W-1:0] r;
        if (v < 21'sd0) begin
            r = -MUL_A_W'(v);
        end else begin
            r = MUL_A_W'(v);
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/bfp_mul.sv =====
// Shared signed multiplier with a registered product.
// Serves the affine map products and the pixel scaling; uses bfp_pkg.
module bfp_mul (
    input  logic                                  aclk,
    input  logic signed [bfp_pkg::MUL_A_W-1:0]    mul_a,
    input  logic signed [bfp_pkg::MUL_B_W-1:0]    mul_b,
    output logic signed [bfp_pkg::MUL_P_W-1:0]    prod
);
    import bfp_pkg::*;

    logic signed [MUL_P_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
    end

    assign prod = prod_reg;

endmodule

// ===== hw/rtl/bfp_bitmap.sv =====
// Pixel bitmap memory, one byte per address, with a clearing sweep after reset.
// Read data is registered and holds until the next read; uses bfp_pkg.
module bfp_bitmap (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  bfp_pkg::bfp_mem_req_t req,
    output logic [7:0]            rd_data,
    output logic                  clr_busy
);
    import bfp_pkg::*;

    logic [7:0]       mem [BM_BYTES];
    logic [7:0]       rd_data_reg;
    logic             clr_busy_reg;
    logic [BM_AW-1:0] clr_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == BM_AW'(BM_BYTES - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_addr_reg] <= 8'h00;
        end else if (req.wr_en) begin
            mem[req.addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clr_busy = clr_busy_reg;

endmodule

// ===== hw/rtl/barnsley_fern_point_plotter_core.sv =====
// Barnsley fern point plotter: sequencer, point state and result register.
// Uses bfp_pkg, bfp_mul (shared multiplier) and bfp_bitmap (pixel memory).
//
//   channel   dir   handshake            payload
//   s_        in    s_tvalid / s_tready  s_tuser = op, s_tdata = sel_value, pix_row, pix_col
//   m_        out   m_tvalid / m_tready  m_tuser = off_image, m_tdata = plot_x, plot_y, pixel_set
//
// A step beat makes six passes through the shared multiplier (four map products, two scale
// products) and a read-modify-write of one bitmap byte; a read beat makes one registered bitmap
// read. A new beat is accepted only once the sequencer has returned to idle.
// After reset the bitmap is cleared one byte a cycle, with s_tready low.
// A finished result waits in the output register; the next beat is accepted meanwhile and
// its result waits in the last state until the output register is free.
module barnsley_fern_point_plotter_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bfp_pkg::S_TDATA_W-1:0]   s_tdata,  // sel_value[6:0], pix_row[14:7], pix_col[22:15], zero[23]
    input  logic                            s_tuser,  // op
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bfp_pkg::M_TDATA_W-1:0]   m_tdata,  // plot_x[7:0], plot_y[15:8], pixel_set[16], zero[23:17]
    output logic                            m_tuser   // off_image
);
    import bfp_pkg::*;

    bfp_state_t state_reg, state_next;

    logic signed [20:0]         point_x_reg, point_y_reg;
    logic                       op_reg;
    logic [1:0]                 map_reg;
    logic [7:0]                 row_reg, col_reg;
    logic signed [MUL_P_W-1:0]  acc_reg;
    logic [Q_W-1:0]             qx_reg;
    logic                       skip_reg;
    logic [7:0]                 res_x_reg, res_y_reg;
    logic [BM_AW-1:0]           addr_reg;
    logic [2:0]                 bit_reg;

    logic                       m_tvalid_reg;
    logic [7:0]                 out_x_reg, out_y_reg;
    logic                       out_off_reg, out_pix_reg;

    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [MUL_P_W-1:0]  prod;

    bfp_mem_req_t               mem_req;
    logic [7:0]                 rd_data;
    logic                       clr_busy;
    logic                       load_out;

    logic signed [MUL_P_W-1:0]  map_sum;
    logic signed [17:0]         map_off;
    logic signed [40:0]         map_rnd;
    logic signed [20:0]         map_new;
    logic signed [15:0]         qx_s, qy_s, px_c, py_c;
    logic                       pix_off;
    logic [31:0]                pix_lin, rd_lin;
    logic                       rd_hit;

    bfp_mul u_mul (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod)
    );

    bfp_bitmap u_bitmap (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (mem_req),
        .rd_data  (rd_data),
        .clr_busy (clr_busy)
    );

    assign s_tready = (state_reg == ST_IDLE) && !clr_busy;

    // round, offset and saturate one map coordinate
    always_comb begin
        map_sum = acc_reg + prod;
        map_off = (state_reg == ST_CX) ? map_coef(map_reg, CF_E) : map_coef(map_reg, CF_F);
        map_rnd = 41'(map_sum >>> 16) + 41'(map_off);
        map_new = sat_q(map_rnd);
    end

    always_comb begin
        qx_s    = signed'({1'b0, qx_reg});
        qy_s    = signed'({1'b0, prod[SHY +: Q_W]});
        px_c    = point_x_reg[20] ? (HALF_W - qx_s) : (HALF_W + qx_s);
        py_c    = point_y_reg[20] ? -qy_s : qy_s;
        pix_off = (px_c < 16'sd0) || (px_c >= W_S) || (py_c < 16'sd0) || (py_c >= H_S);
        pix_lin = 32'(py_c) * IMG_WIDTH + 32'(px_c);
        rd_hit  = (16'(row_reg) < 16'(IMG_HEIGHT)) && (16'(col_reg) < 16'(IMG_WIDTH));
        rd_lin  = 32'(row_reg) * IMG_WIDTH + 32'(col_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        mul_a      = '0;
        mul_b      = '0;
        mem_req    = '0;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    state_next = (s_tuser == OP_READ) ? ST_RADDR : ST_AX;
                end
            end
            ST_AX: begin
                mul_a      = MUL_A_W'(point_x_reg);
                mul_b      = MUL_B_W'(map_coef(map_reg, CF_A));
                state_next = ST_BY;
            end
            ST_BY: begin
                mul_a      = MUL_A_W'(point_y_reg);
                mul_b      = MUL_B_W'(map_coef(map_reg, CF_B));
                state_next = ST_CX;
            end
            ST_CX: begin
                mul_a      = MUL_A_W'(point_x_reg);
                mul_b      = MUL_B_W'(map_coef(map_reg, CF_C));
                state_next = ST_DY;
            end
            ST_DY: begin
                mul_a      = MUL_A_W'(point_y_reg);
                mul_b      = MUL_B_W'(map_coef(map_reg, CF_D));
                state_next = ST_SX;
            end
            ST_SX: begin
                mul_a      = abs_q(point_x_reg);
                mul_b      = SCALE_X_MUL;
                state_next = ST_SY;
            end
            ST_SY: begin
                mul_a      = abs_q(point_y_reg);
                mul_b      = SCALE_Y_MUL;
                state_next = ST_PIX;
            end
            ST_PIX: begin
                mem_req.rd_en = !pix_off;
                mem_req.addr  = BM_AW'(pix_lin >> 3);
                state_next    = ST_WR;
            end
            ST_WR: begin
                mem_req.wr_en   = !skip_reg;
                mem_req.addr    = addr_reg;
                mem_req.wr_data = rd_data | (8'h01 << bit_reg);
                state_next      = ST_DONE;
            end
            ST_RADDR: begin
                mem_req.rd_en = rd_hit;
                mem_req.addr  = BM_AW'(rd_lin >> 3);
                state_next    = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    op_reg  <= s_tuser;
                    map_reg <= pick_map(s_tdata[6:0]);
                    row_reg <= s_tdata[14:7];
                    col_reg <= s_tdata[22:15];
                end
            end
            ST_BY, ST_DY: begin
                acc_reg <= prod + ROUND_BIAS;
            end
            ST_SY: begin
                qx_reg <= prod[SHX +: Q_W];
            end
            ST_PIX: begin
                skip_reg  <= pix_off;
                res_x_reg <= px_c[7:0];
                res_y_reg <= py_c[7:0];
                addr_reg  <= BM_AW'(pix_lin >> 3);
                bit_reg   <= pix_lin[2:0];
            end
            ST_RADDR: begin
                skip_reg <= !rd_hit;
                bit_reg  <= rd_lin[2:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_x_reg <= '0;
            point_y_reg <= '0;
        end else begin
            if (state_reg == ST_CX) begin
                point_x_reg <= map_new;
            end
            if (state_reg == ST_SX) begin
                point_y_reg <= map_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_x_reg   <= (op_reg == OP_READ || skip_reg) ? 8'd0 : res_x_reg;
            out_y_reg   <= (op_reg == OP_READ || skip_reg) ? 8'd0 : res_y_reg;
            out_off_reg <= (op_reg == OP_STEP) && skip_reg;
            out_pix_reg <= (op_reg == OP_READ) && !skip_reg && rd_data[bit_reg];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_off_reg;
    assign m_tdata  = {7'd0, out_pix_reg, out_y_reg, out_x_reg};

    a_clear_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy |-> !s_tready)
        else $error("input accepted during bitmap clear");

    a_off_image_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[16:0] == 17'd0))
        else $error("off-image result carries pixel data");

    a_write_on_step: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_req.wr_en |-> ((state_reg == ST_WR) && (op_reg == OP_STEP)))
        else $error("bitmap written outside a step");

    a_step_starts_map: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == OP_STEP)) |=> (state_reg == ST_AX))
        else $error("step beat did not start the map sequence");

endmodule
